>>> rtl/core/srtc_pkg.sv
// Shared types and constants for the serial clock-calendar shift interface.
// Used by the control unit, the data cells, the top level and the checker.
// No dependencies.
package srtc_pkg;

  // Data register size in bytes; one cell holds one byte
  localparam int DATA_BYTES = 6;
  localparam int DATA_W     = DATA_BYTES * 8;
  localparam int CELL_W     = 8;

  // Calendar value width as it arrives on the request beat
  localparam int TIME_BYTES = 6;
  localparam int TIME_W     = TIME_BYTES * 8;

  localparam int CMD_W = 4;

  // Latched command codes
  localparam logic [CMD_W-1:0] CMD_SHIFT     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_TIME_LOAD = 4'd3;

  // Request beat: one write of the serial lines plus calendar value
  typedef struct packed {
    logic              din;
    logic              clk_req;
    logic              stb;
    logic [TIME_W-1:0] time_value;
  } srtc_req_t;

  // Response beat: output bit and latched command
  typedef struct packed {
    logic             data_out;
    logic [CMD_W-1:0] mode;
  } srtc_rsp_t;

  // Control from the command unit to every data cell
  typedef struct packed {
    logic shift;  // shift the cell row right by one bit
    logic load;   // load the calendar value
    logic feed;   // bit entering the top cell
  } srtc_cell_ctl_t;

endpackage

>>> rtl/core/serial_rtc_shift_interface.sv
// Serial clock-calendar shift interface, top level.
// A response beat is registered into the output buffer when its request beat is taken.
// Throughput: one beat per cycle while the buffer is not full; the state update is a single shift or load.
// A two-entry output buffer keeps taking requests while one response waits.
// Reset (synchronous, active high) clears the cells, the command unit and the buffer count, emptying the buffer.
module serial_rtc_shift_interface (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  srtc_pkg::srtc_req_t  req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output srtc_pkg::srtc_rsp_t  rsp
);
  import srtc_pkg::*;

  logic           push;
  logic           pop;
  srtc_cell_ctl_t ctl;
  srtc_rsp_t      result;
  srtc_rsp_t      head;
  srtc_rsp_t      tail;
  logic [1:0]     cnt;
  logic [1:0]     cnt_next;
  logic [DATA_BYTES:0] chain;
  logic [DATA_BYTES-1:0] lsb_next;

  assign push = req_valid & ~req_stall;
  assign pop  = rsp_valid & ~rsp_stall;

  srtc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .req      (req),
    .lsb_next (lsb_next[0]),
    .ctl      (ctl),
    .result   (result)
  );

  // Row of byte cells; the top cell takes the bit leaving the command shifter
  assign chain[DATA_BYTES] = ctl.feed;

  for (genvar i = 0; i < DATA_BYTES; i++) begin : g_cell
    logic [CELL_W-1:0] load_byte;
    if (i < TIME_BYTES) begin : g_time
      assign load_byte = req.time_value[i*CELL_W +: CELL_W];
    end else begin : g_zero
      assign load_byte = '0;
    end
    srtc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .shift_in  (chain[i+1]),
      .load_byte (load_byte),
      .shift_out (chain[i]),
      .lsb_next  (lsb_next[i])
    );
  end

  // Two-entry response buffer
  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_next = cnt + 2'd1;
      2'b01:   cnt_next = cnt - 2'd1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // Move payload: head drains first, tail holds the second beat
  always_ff @(posedge clk) begin
    priority if (pop && cnt == 2'd2) begin
      head <= tail;
    end else if (pop && push) begin
      head <= result;
    end else if (!pop && push && cnt == 2'd0) begin
      head <= result;
    end else if (!pop && push) begin
      tail <= result;
    end else begin
      // hold both entries
      head <= head;
    end
  end

  assign req_stall = cnt[1];
  assign rsp_valid = |cnt;
  assign rsp       = head;

endmodule

>>> rtl/core/srtc_cell.sv
// One byte cell of the data shift register row.
// Shifts right, taking its top bit from the neighbor above, or loads a byte.
// Depends on srtc_pkg.
module srtc_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  srtc_pkg::srtc_cell_ctl_t        ctl,
  input  logic                            shift_in,
  input  logic [srtc_pkg::CELL_W-1:0]     load_byte,
  output logic                            shift_out,
  output logic                            lsb_next
);
  import srtc_pkg::*;

  logic [CELL_W-1:0] q;
  logic [CELL_W-1:0] q_next;

  // Pick load over shift: the strobe acts after the clock edge
  always_comb begin
    priority if (ctl.load) begin
      q_next = load_byte;
    end else if (ctl.shift) begin
      q_next = {shift_in, q[CELL_W-1:1]};
    end else begin
      q_next = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

  // Hand the low bit to the lower neighbor; report the post-shift low bit
  assign shift_out = q[0];
  assign lsb_next  = ctl.shift ? q[1] : q[0];

endmodule

>>> rtl/core/srtc_ctrl.sv
// Command unit: edge detection, command shifter, latched mode, output bit.
// Drives the cell row and builds the response for each accepted beat.
// Depends on srtc_pkg.
module srtc_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  srtc_pkg::srtc_req_t       req,
  input  logic                      lsb_next,
  output srtc_pkg::srtc_cell_ctl_t  ctl,
  output srtc_pkg::srtc_rsp_t       result
);
  import srtc_pkg::*;

  logic [CMD_W-1:0] cmd;
  logic [CMD_W-1:0] cmd_next;
  logic [CMD_W-1:0] mode;
  logic [CMD_W-1:0] mode_next;
  logic             out_bit;
  logic             out_bit_next;
  logic             last_din;
  logic             last_clk;
  logic             last_stb;
  logic             clk_rise;
  logic             stb_rise;
  logic             refresh;

  // Decode edges and the actions they cause
  always_comb begin
    clk_rise  = push & req.clk_req & ~last_clk;
    stb_rise  = push & req.stb & ~last_stb;
    cmd_next  = clk_rise ? {last_din, cmd[CMD_W-1:1]} : cmd;
    mode_next = stb_rise ? cmd_next : mode;
    ctl.shift = clk_rise & (mode == CMD_SHIFT);
    ctl.feed  = cmd[0];
    ctl.load  = stb_rise & (cmd_next == CMD_TIME_LOAD);
    refresh   = stb_rise & (cmd_next == CMD_SHIFT);
    out_bit_next = (ctl.shift | refresh) ? lsb_next : out_bit;
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd      <= '0;
      mode     <= '0;
      out_bit  <= 1'b0;
      last_din <= 1'b0;
      last_clk <= 1'b0;
      last_stb <= 1'b0;
    end else if (push) begin
      cmd      <= cmd_next;
      mode     <= mode_next;
      out_bit  <= out_bit_next;
      last_din <= req.din;
      last_clk <= req.clk_req;
      last_stb <= req.stb;
    end
  end

  assign result.data_out = out_bit_next;
  assign result.mode     = mode_next;

endmodule

>>> rtl/core/srtc_checker.sv
// Port-level checker for the serial clock-calendar shift interface.
// Bound to the top level below. Depends on srtc_pkg.
module srtc_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input srtc_pkg::srtc_req_t  req,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input srtc_pkg::srtc_rsp_t  rsp
);
  import srtc_pkg::*;

  // Buffer comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

  // Request side stalls only while responses are pending
  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid)
    else $error("request stalled with no pending response");

  // After every accepted beat some response is valid the next cycle
  a_beat_response: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> rsp_valid)
    else $error("accepted beat produced no response");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

endmodule

bind serial_rtc_shift_interface srtc_checker u_srtc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
